// ===== rtl/mlkcp_pkg.sv =====
package mlkcp_pkg;

  localparam int KYBER_Q = 3329;
  localparam int HALF_Q = 1664;
  localparam int DEF_COEFFS_PER_POLY = 256;

  localparam int COEF_W = 16;
  localparam int RED_W = 12;
  localparam int VAL_W = 11;
  localparam int NUM_W = 23;
  localparam int COMP_SHIFT = 35;
  localparam int RECIP_W = 24;
  localparam int QUOT_W = 12;
  localparam int ACC_W = 18;

  localparam logic [RECIP_W-1:0] COMP_RECIP =
    RECIP_W'(((longint'(1) << COMP_SHIFT) + longint'(KYBER_Q) - 1) / longint'(KYBER_Q));

  typedef enum logic [1:0] {
    MODE_D4  = 2'd0,
    MODE_D5  = 2'd1,
    MODE_D10 = 2'd2,
    MODE_D11 = 2'd3
  } mode_t;

  typedef logic [RED_W-1:0] red_tbl_t [256];

  function automatic logic [3:0] width_of_mode(input mode_t mode);
    logic [3:0] d;
    unique case (mode)
      MODE_D4:  d = 4'd4;
      MODE_D5:  d = 4'd5;
      MODE_D10: d = 4'd10;
      MODE_D11: d = 4'd11;
    endcase
    return d;
  endfunction

  // Entry i holds (signed upper byte i times 256) modulo q, in 0..q-1.
  function automatic red_tbl_t red_tbl_init();
    red_tbl_t t;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = ((i < 128) ? i : i - 256) * 256;
      v = v % KYBER_Q;
      if (v < 0) begin
        v = v + KYBER_Q;
      end
      t[i] = RED_W'(v);
    end
    return t;
  endfunction

  localparam red_tbl_t RED_TBL = red_tbl_init();

endpackage

// ===== rtl/mlkem_coeff_compress_pack.sv =====
// ML-KEM coefficient compressor and byte packer. Each transfer on the input
// channel carries one signed coefficient, which is reduced modulo 3329,
// compressed to d bits (d set by cfg_wr_data: 4, 5, 10 or 11) and appended
// LSB first to a bit accumulator; every full byte leaves on the output
// channel, with out_last_byte set on the final byte of each polynomial. A
// coefficient passes four register stages (input, reduction, compression,
// output buffer), and a new coefficient can be taken every cycle while
// in_stall is low. The output channel moves one byte per cycle while
// out_stall is low, and packing waits until the output buffer is empty or
// sends its last byte: d = 4 and 5 run at one coefficient per cycle without
// output stalls, d = 10 and 11 give up to two bytes per coefficient (d/8 on
// average). Write cfg only while the block holds no coefficient.
module mlkem_coeff_compress_pack
  import mlkcp_pkg::*;
#(
  parameter int COEFFS_PER_POLY = DEF_COEFFS_PER_POLY
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [1:0]               cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [COEF_W-1:0] in_coefficient,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               out_packed_byte,
  output logic                     out_last_byte
);

  localparam int IDX_W = (COEFFS_PER_POLY > 1) ? $clog2(COEFFS_PER_POLY) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(COEFFS_PER_POLY - 1);

  mode_t                bits_mode_r;
  logic                 s0_v_r;
  logic [COEF_W-1:0]    coef_r;
  logic                 s1_v_r;
  logic [RED_W-1:0]     red_r;
  logic [RED_W-1:0]     red_nxt;
  logic                 s2_v_r;
  logic [VAL_W-1:0]     val_r;
  logic [VAL_W-1:0]     val_nxt;
  logic [6:0]           pend_bits_r;
  logic [6:0]           pend_bits_nxt;
  logic [2:0]           pend_cnt_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx_nxt;
  logic [7:0]           ob0_r;
  logic [7:0]           ob1_r;
  logic                 ol0_r;
  logic                 ol1_r;
  logic [1:0]           ocnt_r;

  logic                 s0_ready;
  logic                 s1_ready;
  logic                 s2_ready;
  logic                 pk_ready;
  logic                 pk_load;
  logic                 in_xfer;
  logic                 out_xfer;
  logic [3:0]           d;
  logic [RED_W:0]       red_sum;
  logic [NUM_W-1:0]     num;
  logic [NUM_W+RECIP_W-1:0] prod;
  logic [QUOT_W-1:0]    quot;
  logic [VAL_W-1:0]     val_mask;
  logic [ACC_W-1:0]     acc;
  logic [4:0]           cnt_sum;
  logic [1:0]           pk_nbytes;
  logic                 final_coeff;

  assign d = width_of_mode(bits_mode_r);

  assign out_xfer = out_valid && !out_stall;
  assign pk_ready = (ocnt_r == 2'd0) || ((ocnt_r == 2'd1) && out_xfer);
  assign pk_load = s2_v_r && pk_ready;
  assign s2_ready = !s2_v_r || pk_ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign s0_ready = !s0_v_r || s1_ready;
  assign in_stall = !s0_ready;
  assign in_xfer = in_valid && s0_ready;

  // Signed upper byte through the table, unsigned lower byte added after.
  always_comb begin
    red_sum = {1'b0, RED_TBL[coef_r[15:8]]} + (RED_W+1)'(coef_r[7:0]);
    if (red_sum >= (RED_W+1)'(KYBER_Q)) begin
      red_nxt = RED_W'(red_sum - (RED_W+1)'(KYBER_Q));
    end else begin
      red_nxt = red_sum[RED_W-1:0];
    end
  end

  // Rounded quotient by q via the reciprocal; exact for every numerator below 2^23.
  always_comb begin
    num = (NUM_W'(red_r) << d) + NUM_W'(HALF_Q);
    prod = (NUM_W+RECIP_W)'(num) * (NUM_W+RECIP_W)'(COMP_RECIP);
    quot = prod[COMP_SHIFT +: QUOT_W];
    val_mask = (VAL_W'(1) << d) - VAL_W'(1);
    val_nxt = quot[VAL_W-1:0] & val_mask;
  end

  always_comb begin
    acc = ACC_W'(pend_bits_r) | (ACC_W'(val_r) << pend_cnt_r);
    cnt_sum = 5'(pend_cnt_r) + 5'(d);
    if (cnt_sum >= 5'd16) begin
      pk_nbytes = 2'd2;
      pend_bits_nxt = 7'(acc[17:16]);
    end else if (cnt_sum >= 5'd8) begin
      pk_nbytes = 2'd1;
      pend_bits_nxt = acc[14:8];
    end else begin
      pk_nbytes = 2'd0;
      pend_bits_nxt = acc[6:0];
    end
    final_coeff = (idx_r == IDX_LAST);
    idx_nxt = final_coeff ? '0 : idx_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_mode_r <= MODE_D10;
    end else if (cfg_wr_en) begin
      bits_mode_r <= mode_t'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_v_r <= in_valid;
      end
      if (s1_ready) begin
        s1_v_r <= s0_v_r;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      coef_r <= in_coefficient;
    end
    if (s1_ready) begin
      red_r <= red_nxt;
    end
    if (s2_ready) begin
      val_r <= val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r <= '0;
      idx_r <= '0;
    end else if (pk_load) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r <= cnt_sum[2:0];
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else if (pk_load) begin
      ocnt_r <= pk_nbytes;
    end else if (out_xfer) begin
      ocnt_r <= ocnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pk_load) begin
      ob0_r <= acc[7:0];
      ob1_r <= acc[15:8];
      ol0_r <= final_coeff && (pk_nbytes == 2'd1);
      ol1_r <= final_coeff;
    end else if (out_xfer) begin
      ob0_r <= ob1_r;
      ol0_r <= ol1_r;
    end
  end

  assign out_valid = (ocnt_r != 2'd0);
  assign out_packed_byte = ob0_r;
  assign out_last_byte = ol0_r;

`ifndef SYNTHESIS
  a_ocnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_first_of_pair_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == 2'd2) |-> !ol0_r)
    else $error("first byte of a pair marked as last");

  a_pair_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (pk_load && (pk_nbytes == 2'd2)) |=> (ocnt_r == 2'd2))
    else $error("two-byte load did not fill the output buffer");

  a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_bits_r >> pend_cnt_r) == 7'd0)
    else $error("pending bits above the pending count");

  a_reduced_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (red_r < RED_W'(KYBER_Q)))
    else $error("reduced coefficient not below q");

  a_value_width: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> ((val_r >> d) == VAL_W'(0)))
    else $error("compressed value wider than d");
`endif

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mlkcp_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS = 1800;

  typedef struct {
    logic [7:0] packed_byte;
    logic       last_byte;
  } packed_out_t;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic [1:0]               cfg_wr_data;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [COEF_W-1:0] in_coefficient;
  logic                     out_valid;
  logic                     out_stall;
  logic [7:0]               out_packed_byte;
  logic                     out_last_byte;

  // Shadow of the packer: width setting, leftover bits and position in the polynomial.
  mode_t       width_mode = MODE_D10;
  int unsigned leftover_bits = 0;
  int unsigned leftover_count = 0;
  int unsigned coeff_pos = 0;

  packed_out_t packed_stream[$];
  int          mismatches = 0;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;
  int          hold_left = 0;

  mlkem_coeff_compress_pack #(
    .COEFFS_PER_POLY(DEF_COEFFS_PER_POLY)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_coefficient(in_coefficient),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_packed_byte(out_packed_byte),
    .out_last_byte(out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic int rand_coeff();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return int'($urandom_range(0, 65535)) - 32768;
      4, 5, 6: return $urandom_range(0, KYBER_Q - 1);
      7: return -int'($urandom_range(1, KYBER_Q));
      8: return KYBER_Q * (int'($urandom_range(0, 18)) - 9) + int'($urandom_range(0, 2)) - 1;
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return 32767 - int'($urandom_range(0, 3));
        end
        return -32768 + int'($urandom_range(0, 3));
      end
    endcase
  endfunction

  // Reduces, compresses and packs one coefficient; queues every byte it completes.
  function automatic void compress_and_pack(input logic signed [COEF_W-1:0] coef);
    int          c;
    int unsigned d;
    int unsigned v;
    int unsigned acc;
    int unsigned cnt;
    bit          final_coeff;
    packed_out_t made[$];
    packed_out_t one;
    c = coef;
    c = c % KYBER_Q;
    if (c < 0) begin
      c = c + KYBER_Q;
    end
    case (width_mode)
      MODE_D4: d = 4;
      MODE_D5: d = 5;
      MODE_D10: d = 10;
      default: d = 11;
    endcase
    v = ((int'(c) << d) + HALF_Q) / KYBER_Q;
    v = v & ((1 << d) - 1);
    acc = leftover_bits | (v << leftover_count);
    cnt = leftover_count + d;
    final_coeff = (coeff_pos == DEF_COEFFS_PER_POLY - 1);
    while (cnt >= 8) begin
      one.packed_byte = acc[7:0];
      one.last_byte = 1'b0;
      made.push_back(one);
      acc = acc >> 8;
      cnt = cnt - 8;
    end
    if (final_coeff && made.size() > 0) begin
      made[made.size() - 1].last_byte = 1'b1;
    end
    foreach (made[i]) begin
      packed_stream.push_back(made[i]);
    end
    leftover_bits = acc & 32'h7F;
    leftover_count = cnt & 32'h7;
    coeff_pos = final_coeff ? 0 : coeff_pos + 1;
  endfunction

  task automatic send_coeff(input int value);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_coefficient <= COEF_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coefficient <= COEF_W'(value);
    do begin
      @(posedge clk);
    end while (in_stall);
    compress_and_pack(COEF_W'(value));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (packed_stream.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_width(input mode_t mode);
    wait_drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    width_mode = mode;
  endtask

  task automatic test_directed();
    int d10_vals[9] = '{0, 1, -1, 3328, 3329, 1664, 1665, 32767, -32768};
    int d4_vals[4] = '{0, 1664, -1664, 208};
    int d5_vals[5] = '{3328, 104, -1, 32767, -32768};
    int d11_vals[7] = '{0, 1, 3328, 1664, -32768, 32767, -1};
    foreach (d10_vals[i]) send_coeff(d10_vals[i]);
    set_width(MODE_D4);
    foreach (d4_vals[i]) send_coeff(d4_vals[i]);
    set_width(MODE_D5);
    foreach (d5_vals[i]) send_coeff(d5_vals[i]);
    set_width(MODE_D11);
    foreach (d11_vals[i]) send_coeff(d11_vals[i]);
  endtask

  task automatic test_width_sweep();
    mode_t order[4] = '{MODE_D11, MODE_D4, MODE_D5, MODE_D10};
    int    sent;
    int    phase;
    int    len;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      set_width((phase < 4) ? order[phase] : mode_t'($urandom_range(0, 3)));
      tx_gaps_on = (phase % 3 != 2);
      rx_gaps_on = (phase % 4 != 3);
      len = $urandom_range(60, 300);
      repeat (len) send_coeff(rand_coeff());
      sent = sent + len;
      phase = phase + 1;
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_full_rate();
    set_width(MODE_D11);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (80) send_coeff(rand_coeff());
    set_width(MODE_D4);
    repeat (80) send_coeff(rand_coeff());
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_output_holdoff();
    set_width(MODE_D11);
    tx_gaps_on = 1'b0;
    hold_left = 300;
    repeat (60) send_coeff(rand_coeff());
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    set_width(MODE_D10);
    repeat (30) send_coeff(rand_coeff());
    wait_drain();
    repeat (30) send_coeff(rand_coeff());
  endtask

  // Receiver: random stall stretches, none when rx gaps are off, or one long hold when requested.
  initial begin
    int run_left;
    run_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
        run_left = 0;
      end else if (!rx_gaps_on) begin
        out_stall <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        run_left = gap_len();
      end
    end
  end

  // Each byte transfer is compared with the oldest predicted byte.
  always @(posedge clk) begin
    packed_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (packed_stream.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, got %02h last %0b", $time,
                 out_packed_byte, out_last_byte);
      end else begin
        want = packed_stream.pop_front();
        if (out_packed_byte !== want.packed_byte) begin
          mismatches++;
          $display("%0t: packed_byte mismatch, expected %02h, got %02h", $time,
                   want.packed_byte, out_packed_byte);
        end
        if (out_last_byte !== want.last_byte) begin
          mismatches++;
          $display("%0t: last_byte mismatch, expected %0b, got %0b", $time,
                   want.last_byte, out_last_byte);
        end
      end
    end
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("mlkem_coeff_compress_pack verification failed");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= MODE_D10;
    in_valid <= 1'b0;
    in_coefficient <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_width_sweep();
    test_full_rate();
    test_output_holdoff();
    test_sender_pause();
    wait_drain();
    if (mismatches == 0 && packed_stream.size() == 0) begin
      $display("mlkem_coeff_compress_pack verification clean");
    end else begin
      $display("mlkem_coeff_compress_pack verification failed");
    end
    $finish;
  end

endmodule
